### sv/fdf_pkg.sv
// ----------------------------------------------------------------------------
// fdf_pkg
// Shared types and constants of the fractional delay filter.
// ----------------------------------------------------------------------------
package fdf_pkg;

	localparam int NCOEF  = 6;
	localparam int QBITS  = 14;
	localparam int SMP_W  = 16;
	localparam int COEF_W = 20;
	localparam int ORD_W  = 3;
	localparam int IDX_W  = 3;
	localparam int MUL_W  = COEF_W + SMP_W;
	localparam int PROD_W = MUL_W + 2;
	localparam int ACC_W  = PROD_W + 3;

	localparam logic signed [COEF_W-1:0] UNITY = COEF_W'(1 << QBITS);

	typedef enum logic [IDX_W-1:0] {
		REG_MODE  = 3'd0,
		REG_ORDER = 3'd1,
		REG_COEF0 = 3'd2,
		REG_COEF1 = 3'd3,
		REG_COEF2 = 3'd4,
		REG_COEF3 = 3'd5,
		REG_COEF4 = 3'd6,
		REG_COEF5 = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		MODE_LAGRANGE = 1'b0,
		MODE_THIRAN   = 1'b1
	} filter_mode_t;

	typedef logic signed [SMP_W-1:0]  sample_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [MUL_W-1:0]  mul_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef struct packed {
		logic accept;
		logic y_push;
		logic s1_full;
	} cell_ctl_t;

endpackage

### sv/fdf_cell.sv
// ----------------------------------------------------------------------------
// fdf_cell
// One tap: holds one input and one output history sample, shifts the input
// sample and forms the tap's product term when an item is accepted, and shifts the output sample when an item moves on.
// ----------------------------------------------------------------------------
module fdf_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  fdf_pkg::cell_ctl_t  ctl,
	input  fdf_pkg::sample_t    x_in,
	input  fdf_pkg::sample_t    y_in,
	input  fdf_pkg::sample_t    y_near,
	input  fdf_pkg::coef_t      kx,
	input  fdf_pkg::coef_t      ky,
	output fdf_pkg::sample_t    x_q,
	output fdf_pkg::sample_t    y_q,
	output fdf_pkg::prod_t      prod_s1
);

	fdf_pkg::sample_t                    y_fut;
	logic signed [fdf_pkg::SMP_W:0]      y_neg;
	fdf_pkg::mul_t                       px;
	logic signed [fdf_pkg::MUL_W:0]      py;

	// output history as it will stand once the item ahead has been computed
	always_comb begin
		y_fut = ctl.s1_full ? y_near : y_q;
		y_neg = -((fdf_pkg::SMP_W + 1)'(y_fut));
		px    = kx * x_q;
		py    = ky * y_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else begin
			if (ctl.accept) x_q <= x_in;
			if (ctl.y_push) y_q <= y_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) prod_s1 <= fdf_pkg::PROD_W'(px) + fdf_pkg::PROD_W'(py);
	end

endmodule

### sv/fdf_sum.sv
// ----------------------------------------------------------------------------
// fdf_sum
// Adds the tap terms, subtracts the feedback term of the latest output, rounds half
// up at Q.14 and saturates to 16 bits.
// ----------------------------------------------------------------------------
module fdf_sum #(
	parameter int NTAP = 5
) (
	input  fdf_pkg::prod_t   prod_s1 [NTAP],
	input  fdf_pkg::mul_t    p0_s1,
	input  fdf_pkg::coef_t   c1,
	input  fdf_pkg::sample_t y_last,
	output fdf_pkg::sample_t y_new
);

	localparam int Q_W = fdf_pkg::ACC_W - fdf_pkg::QBITS;

	fdf_pkg::acc_t         acc;
	fdf_pkg::acc_t         rnd;
	fdf_pkg::mul_t         pfb;
	logic signed [Q_W-1:0] q;

	always_comb begin
		pfb = c1 * y_last;
		acc = fdf_pkg::ACC_W'(p0_s1) - fdf_pkg::ACC_W'(pfb);
		for (int j = 0; j < NTAP; j++) acc = acc + fdf_pkg::ACC_W'(prod_s1[j]);
		rnd = acc + fdf_pkg::ACC_W'(1 << (fdf_pkg::QBITS - 1));
		q   = Q_W'(rnd >>> fdf_pkg::QBITS);
		if (q > Q_W'(32767))       y_new = 16'sh7FFF;
		else if (q < Q_W'(-32768)) y_new = 16'sh8000;
		else                       y_new = fdf_pkg::SMP_W'(q);
	end

endmodule

### sv/fractional_delay_filter.sv
// ----------------------------------------------------------------------------
// fractional_delay_filter
// Lagrange FIR / Thiran allpass fractional delay on a 16-bit sample stream.
// ----------------------------------------------------------------------------
// Input channel: sample_in with in_valid; the block raises in_stall when it
// cannot take an item. Output channel: sample_out with out_valid; the
// receiver raises out_stall to hold the item, which then stays unchanged.
// Configuration: cfg_index/cfg_data with cfg_valid/cfg_ready (always ready);
// index 0 mode, 1 order, 2..7 coefficients c0..c5. Write only while idle.
// One item in, one item out, one item per cycle sustained unless the output
// stalls. The taps register their products at acceptance; as the item moves
// on, its terms are summed, rounded and saturated into the output register.
// The allpass feedback closes in the sum stage: one multiply and the final sum.
// A stalled output holds the item and the item behind it; input then stalls.
// Reset clears both sample histories, mode to Lagrange, order to 5, all
// coefficients to zero. Orders above min(MAX_ORDER, 5) act as that limit.
// ----------------------------------------------------------------------------
module fractional_delay_filter #(
	parameter int MAX_ORDER = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  fdf_pkg::sample_t        sample_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output fdf_pkg::sample_t        sample_out,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [fdf_pkg::IDX_W-1:0] cfg_index,
	input  fdf_pkg::coef_t          cfg_data
);

	localparam int NE = (MAX_ORDER < fdf_pkg::NCOEF - 1) ? MAX_ORDER : fdf_pkg::NCOEF - 1;

	fdf_pkg::filter_mode_t         mode_q;
	logic [fdf_pkg::ORD_W-1:0]     order_q;
	fdf_pkg::coef_t                coef_q [fdf_pkg::NCOEF];
	logic [fdf_pkg::ORD_W-1:0]     n_eff;

	fdf_pkg::coef_t                kx [NE+1];
	fdf_pkg::coef_t                ky [NE];
	fdf_pkg::coef_t                c1;

	fdf_pkg::sample_t              x_hist [NE];
	fdf_pkg::sample_t              y_hist [NE];
	fdf_pkg::prod_t                prod_s1 [NE];
	fdf_pkg::mul_t                 p0_s1;
	fdf_pkg::sample_t              y_new;
	fdf_pkg::sample_t              sample_out_q;
	fdf_pkg::cell_ctl_t            ctl;

	logic valid_s1;
	logic out_valid_q;
	logic accept;
	logic s1_move;
	logic cfg_we;

	// --- configuration ---
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= fdf_pkg::MODE_LAGRANGE;
			order_q <= fdf_pkg::ORD_W'(5);
			for (int i = 0; i < fdf_pkg::NCOEF; i++) coef_q[i] <= '0;
		end else if (cfg_we) begin
			case (fdf_pkg::cfg_reg_t'(cfg_index))
				fdf_pkg::REG_MODE:  mode_q  <= fdf_pkg::filter_mode_t'(cfg_data[0]);
				fdf_pkg::REG_ORDER: order_q <= cfg_data[fdf_pkg::ORD_W-1:0];
				default: begin
					for (int i = 0; i < fdf_pkg::NCOEF; i++) begin
						if (cfg_index == fdf_pkg::IDX_W'(fdf_pkg::REG_COEF0 + i))
							coef_q[i] <= cfg_data;
					end
				end
			endcase
		end
	end

	// --- tap coefficients for the current mode and order ---
	always_comb begin
		n_eff = (order_q > fdf_pkg::ORD_W'(NE)) ? fdf_pkg::ORD_W'(NE) : order_q;
		for (int m = 0; m <= NE; m++) begin
			kx[m] = '0;
			if (mode_q == fdf_pkg::MODE_LAGRANGE) begin
				if (fdf_pkg::ORD_W'(m) <= n_eff) kx[m] = coef_q[m];
			end else begin
				if (fdf_pkg::ORD_W'(m) == n_eff) kx[m] = fdf_pkg::UNITY;
				for (int k = m + 1; k <= NE; k++) begin
					if (n_eff == fdf_pkg::ORD_W'(k)) kx[m] = coef_q[k-m];
				end
			end
		end
		// newest output feeds back in the sum stage, not in the first tap
		ky[0] = '0;
		for (int n = 2; n <= NE; n++) begin
			ky[n-1] = (mode_q == fdf_pkg::MODE_THIRAN && fdf_pkg::ORD_W'(n) <= n_eff)
				? coef_q[n] : '0;
		end
		c1 = (mode_q == fdf_pkg::MODE_THIRAN && n_eff != '0) ? coef_q[1] : '0;
	end

	// --- handshake ---
	assign s1_move  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~s1_move;
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		ctl.accept  = accept;
		ctl.y_push  = s1_move;
		ctl.s1_full = valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)       valid_s1 <= 1'b1;
			else if (s1_move) valid_s1 <= 1'b0;
			if (s1_move)                     out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	// --- tap row ---
	for (genvar j = 0; j < NE; j++) begin : g_tap
		fdf_pkg::sample_t x_src;
		fdf_pkg::sample_t y_src;
		fdf_pkg::sample_t y_nb;

		if (j == 0) begin : g_head
			assign x_src = sample_in;
			assign y_src = y_new;
			assign y_nb  = '0;
		end else begin : g_body
			assign x_src = x_hist[j-1];
			assign y_src = y_hist[j-1];
			assign y_nb  = y_hist[j-1];
		end

		fdf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.x_in    (x_src),
			.y_in    (y_src),
			.y_near  (y_nb),
			.kx      (kx[j+1]),
			.ky      (ky[j]),
			.x_q     (x_hist[j]),
			.y_q     (y_hist[j]),
			.prod_s1 (prod_s1[j])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) p0_s1 <= kx[0] * sample_in;
	end

	// --- sum, round, saturate ---
	fdf_sum #(
		.NTAP (NE)
	) u_sum (
		.prod_s1 (prod_s1),
		.p0_s1   (p0_s1),
		.c1      (c1),
		.y_last  (y_hist[0]),
		.y_new   (y_new)
	);

	always_ff @(posedge clk) begin
		if (s1_move) sample_out_q <= y_new;
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

`ifndef SYNTH
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1 && x_hist[0] == $past(sample_in))
		else $error("accepted item not captured");

	a_move_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> out_valid && y_hist[0] == sample_out)
		else $error("output history out of step with output");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && out_stall |=> valid_s1 && $stable(y_hist[0]))
		else $error("item lost under output stall");

	a_stall_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_move |=> $stable(y_hist[0]))
		else $error("output history moved without an item");
`endif

endmodule
